>>> rtl/core/pst_pkg.sv
package pst_pkg;

  // Capacity of one batch
  localparam int MAX_JOBS = 16;

  // Field widths
  localparam int FLD_W  = 8;
  localparam int TIME_W = 12;
  localparam int AVG_W  = 20;

  // Internal widths that follow from the capacity
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int EL_W   = $clog2(MAX_JOBS * 255 + 1);
  localparam int TOT_W  = $clog2(MAX_JOBS * (MAX_JOBS + 1) / 2 * 255 + 1);
  localparam int NUM_W  = TOT_W + 8;
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam int TSAT_W = (EL_W > TIME_W) ? EL_W + 1 : TIME_W + 1;
  localparam int ASAT_W = (NUM_W > AVG_W) ? NUM_W + 1 : AVG_W + 1;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [AVG_W-1:0]  AVG_MAX  = '1;

  typedef struct packed {
    logic [FLD_W-1:0] tag;
    logic [FLD_W-1:0] dur;
    logic [FLD_W-1:0] pri;
  } job_t;

  // One entry of the queue between front and back
  typedef struct packed {
    job_t             job;
    logic             last;
    logic             drop;
    logic [CNT_W-1:0] cnt;
  } qent_t;

  function automatic logic [TIME_W-1:0] sat_time(input logic [EL_W-1:0] v);
    logic [TSAT_W-1:0] w;
    w = TSAT_W'(v);
    if (w > TSAT_W'(TIME_MAX)) begin
      return TIME_MAX;
    end
    return w[TIME_W-1:0];
  endfunction

  function automatic logic [AVG_W-1:0] sat_avg(input logic [NUM_W-1:0] v);
    logic [ASAT_W-1:0] w;
    w = ASAT_W'(v);
    if (w > ASAT_W'(AVG_MAX)) begin
      return AVG_MAX;
    end
    return w[AVG_W-1:0];
  endfunction

endpackage

>>> rtl/core/pst_front.sv
module pst_front import pst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [FLD_W-1:0] job_tag_i,
  input  logic [FLD_W-1:0] job_duration_i,
  input  logic [FLD_W-1:0] job_priority_i,
  input  logic             batch_end_i,
  output logic             push_o,
  output qent_t            push_data_o,
  input  logic             full_i
);

  typedef enum logic {
    F_LOAD,
    F_DRAIN
  } state_e;

  state_e           st_q, st_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic             drop_q, drop_d;
  job_t             jobs_q [MAX_JOBS];
  job_t             jobs_d [MAX_JOBS];
  logic [MAX_JOBS-1:0] gt;
  logic             accept;
  logic             store;
  job_t             new_job;

  assign in_ready_o = (st_q == F_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign store      = accept && (cnt_q < CNT_W'(MAX_JOBS));
  assign new_job    = '{tag: job_tag_i, dur: job_duration_i, pri: job_priority_i};

  // Hand the head of the sorted store to the queue during drain
  assign push_o           = (st_q == F_DRAIN) && !full_i;
  assign push_data_o.job  = jobs_q[0];
  assign push_data_o.last = (left_q == CNT_W'(1));
  assign push_data_o.drop = drop_q;
  assign push_data_o.cnt  = cnt_q;

  // Mark stored entries that rank behind the new job
  always_comb begin
    for (int i = 0; i < MAX_JOBS; i++) begin
      gt[i] = (CNT_W'(i) < cnt_q) && (jobs_q[i].pri > job_priority_i);
    end
  end

  // Insert in place on load, shift toward the head on drain
  always_comb begin
    jobs_d = jobs_q;
    if (store) begin
      if (gt[0] || (cnt_q == '0)) begin
        jobs_d[0] = new_job;
      end
      for (int i = 1; i < MAX_JOBS; i++) begin
        if ((CNT_W'(i) <= cnt_q) && gt[i-1]) begin
          jobs_d[i] = jobs_q[i-1];
        end else if (gt[i] || (CNT_W'(i) == cnt_q)) begin
          jobs_d[i] = new_job;
        end
      end
    end else if (push_o) begin
      for (int i = 0; i < MAX_JOBS - 1; i++) begin
        jobs_d[i] = jobs_q[i+1];
      end
    end
  end

  // Sequence load and drain
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    left_d = left_q;
    drop_d = drop_q;
    unique case (st_q)
      F_LOAD: begin
        if (accept) begin
          if (store) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (batch_end_i) begin
            st_d   = F_DRAIN;
            left_d = cnt_d;
          end
        end
      end
      F_DRAIN: begin
        if (push_o) begin
          left_d = left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            st_d   = F_LOAD;
            cnt_d  = '0;
            drop_d = 1'b0;
          end
        end
      end
      default: st_d = F_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_LOAD;
      cnt_q  <= '0;
      left_q <= '0;
      drop_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      left_q <= left_d;
      drop_q <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    jobs_q <= jobs_d;
  end

endmodule

>>> rtl/core/pst_fifo.sv
module pst_fifo import pst_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output qent_t head_o
);

  logic [1:0] n_q, n_d;
  qent_t      ent_q [2];
  logic [1:0] wr_pos;
  logic       wr_idx;

  assign full_o  = (n_q == 2'd2);
  assign valid_o = (n_q != 2'd0);
  assign head_o  = ent_q[0];
  assign wr_pos  = n_q - {1'b0, pop_i};
  assign wr_idx  = wr_pos[0];

  // Track fill level
  always_comb begin
    n_d = n_q;
    if (push_i && !pop_i) begin
      n_d = n_q + 2'd1;
    end else if (pop_i && !push_i) begin
      n_d = n_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= 2'd0;
    end else begin
      n_q <= n_d;
    end
  end

  // Advance on pop, then write behind the last held entry
  always_ff @(posedge clk_i) begin
    if (push_i && !wr_idx) begin
      ent_q[0] <= push_data_i;
    end else if (pop_i) begin
      ent_q[0] <= ent_q[1];
    end
    if (push_i && wr_idx) begin
      ent_q[1] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/pst_div.sv
module pst_div import pst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] den_i,
  input  logic [NUM_W-1:0] num_a_i,
  input  logic [NUM_W-1:0] num_b_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_a_o,
  output logic [NUM_W-1:0] quo_b_o
);

  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  den_q;
  logic [NUM_W-1:0]  na_q, nb_q;
  logic [CNT_W:0]    ra_q, rb_q;
  logic [CNT_W:0]    ra_sh, rb_sh;
  logic              ga, gb;

  assign busy_o  = (step_q != '0);
  assign quo_a_o = na_q;
  assign quo_b_o = nb_q;

  // One restoring step per cycle on both lanes
  assign ra_sh = {ra_q[CNT_W-1:0], na_q[NUM_W-1]};
  assign rb_sh = {rb_q[CNT_W-1:0], nb_q[NUM_W-1]};
  assign ga    = (ra_sh >= {1'b0, den_q});
  assign gb    = (rb_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= STEP_W'(NUM_W);
    end else if (busy_o) begin
      step_q <= step_q - STEP_W'(1);
    end
  end

  // Dividend register collects quotient bits from the right
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      na_q  <= num_a_i;
      nb_q  <= num_b_i;
      ra_q  <= '0;
      rb_q  <= '0;
    end else if (busy_o) begin
      na_q <= {na_q[NUM_W-2:0], ga};
      nb_q <= {nb_q[NUM_W-2:0], gb};
      ra_q <= ga ? (ra_sh - {1'b0, den_q}) : ra_sh;
      rb_q <= gb ? (rb_sh - {1'b0, den_q}) : rb_sh;
    end
  end

endmodule

>>> rtl/core/pst_back.sv
module pst_back import pst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  qent_t             q_head_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [FLD_W-1:0]  out_tag_o,
  output logic [FLD_W-1:0]  out_priority_o,
  output logic [FLD_W-1:0]  out_duration_o,
  output logic [TIME_W-1:0] wait_time_o,
  output logic [TIME_W-1:0] turnaround_time_o,
  output logic [AVG_W-1:0]  avg_wait_q8_o,
  output logic [AVG_W-1:0]  avg_turnaround_q8_o,
  output logic              overflowed_o,
  output logic              final_res_o
);

  typedef enum logic {
    B_RUN,
    B_DIV
  } state_e;

  state_e            st_q;
  logic [EL_W-1:0]   elapsed_q;
  logic [TOT_W-1:0]  tot_wt_q, tot_tat_q;
  logic              out_v_q;
  logic              out_free;
  logic [EL_W-1:0]   tat;
  logic [TOT_W-1:0]  fin_wt, fin_tat;
  logic              div_start, div_busy;
  logic [NUM_W-1:0]  quo_wt, quo_tat;
  logic              emit_job, emit_fin;
  // Held fields of the closing job while the averages settle
  job_t              hold_job_q;
  logic [TIME_W-1:0] hold_wt_q, hold_tat_q;
  logic              hold_drop_q;

  assign out_free    = !out_v_q || out_ready_i;
  assign out_valid_o = out_v_q;

  assign tat     = elapsed_q + EL_W'(q_head_i.job.dur);
  assign fin_wt  = tot_wt_q + TOT_W'(elapsed_q);
  assign fin_tat = tot_tat_q + TOT_W'(tat);

  assign q_pop_o   = (st_q == B_RUN) && q_valid_i && (q_head_i.last || out_free);
  assign emit_job  = q_pop_o && !q_head_i.last;
  assign div_start = q_pop_o && q_head_i.last;
  assign emit_fin  = (st_q == B_DIV) && !div_busy && out_free;

  pst_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .den_i   (q_head_i.cnt),
    .num_a_i ({fin_wt, 8'd0}),
    .num_b_i ({fin_tat, 8'd0}),
    .busy_o  (div_busy),
    .quo_a_o (quo_wt),
    .quo_b_o (quo_tat)
  );

  // Run the sums, hold the closing job and present results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= B_RUN;
      elapsed_q <= '0;
      tot_wt_q  <= '0;
      tot_tat_q <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (emit_job || emit_fin) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      unique case (st_q)
        B_RUN: begin
          if (emit_job) begin
            elapsed_q <= tat;
            tot_wt_q  <= fin_wt;
            tot_tat_q <= fin_tat;
          end else if (div_start) begin
            elapsed_q <= '0;
            tot_wt_q  <= '0;
            tot_tat_q <= '0;
            st_q      <= B_DIV;
          end
        end
        B_DIV: begin
          if (emit_fin) begin
            st_q <= B_RUN;
          end
        end
        default: st_q <= B_RUN;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      hold_job_q  <= q_head_i.job;
      hold_wt_q   <= sat_time(elapsed_q);
      hold_tat_q  <= sat_time(tat);
      hold_drop_q <= q_head_i.drop;
    end
    if (emit_job) begin
      out_tag_o           <= q_head_i.job.tag;
      out_priority_o      <= q_head_i.job.pri;
      out_duration_o      <= q_head_i.job.dur;
      wait_time_o         <= sat_time(elapsed_q);
      turnaround_time_o   <= sat_time(tat);
      avg_wait_q8_o       <= '0;
      avg_turnaround_q8_o <= '0;
      overflowed_o        <= q_head_i.drop;
      final_res_o         <= 1'b0;
    end else if (emit_fin) begin
      out_tag_o           <= hold_job_q.tag;
      out_priority_o      <= hold_job_q.pri;
      out_duration_o      <= hold_job_q.dur;
      wait_time_o         <= hold_wt_q;
      turnaround_time_o   <= hold_tat_q;
      avg_wait_q8_o       <= sat_avg(quo_wt);
      avg_turnaround_q8_o <= sat_avg(quo_tat);
      overflowed_o        <= hold_drop_q;
      final_res_o         <= 1'b1;
    end
  end

endmodule

>>> rtl/core/priority_schedule_timing.sv
// Non-preemptive priority scheduler for one batch of up to MAX_JOBS jobs.
// Jobs load one per cycle and are insertion-sorted on arrival by ascending
// priority number, equal priorities staying in arrival order; jobs past
// capacity are dropped and flagged on every result of the batch. The job
// with batch_end set closes the batch: the input then stays not ready while
// the sorted store drains into a two-entry queue, one job per cycle while
// the queue is not full. The back end emits one result per cycle while
// results are taken, with waiting and turnaround times (saturated at
// 4095), and before the last result runs a bit-serial divider that forms
// both Q8 averages.
module priority_schedule_timing import pst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FLD_W-1:0]  job_tag_i,
  input  logic [FLD_W-1:0]  job_duration_i,
  input  logic [FLD_W-1:0]  job_priority_i,
  input  logic              batch_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [FLD_W-1:0]  out_tag_o,
  output logic [FLD_W-1:0]  out_priority_o,
  output logic [FLD_W-1:0]  out_duration_o,
  output logic [TIME_W-1:0] wait_time_o,
  output logic [TIME_W-1:0] turnaround_time_o,
  output logic [AVG_W-1:0]  avg_wait_q8_o,
  output logic [AVG_W-1:0]  avg_turnaround_q8_o,
  output logic              overflowed_o,
  output logic              final_res_o
);

  logic  push, full, pop, q_valid;
  qent_t push_data, q_head;

  pst_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .job_tag_i      (job_tag_i),
    .job_duration_i (job_duration_i),
    .job_priority_i (job_priority_i),
    .batch_end_i    (batch_end_i),
    .push_o         (push),
    .push_data_o    (push_data),
    .full_i         (full)
  );

  pst_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  pst_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_head_i            (q_head),
    .q_pop_o             (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .out_tag_o           (out_tag_o),
    .out_priority_o      (out_priority_o),
    .out_duration_o      (out_duration_o),
    .wait_time_o         (wait_time_o),
    .turnaround_time_o   (turnaround_time_o),
    .avg_wait_q8_o       (avg_wait_q8_o),
    .avg_turnaround_q8_o (avg_turnaround_q8_o),
    .overflowed_o        (overflowed_o),
    .final_res_o         (final_res_o)
  );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import pst_pkg::*;

  // One expected or observed schedule entry
  typedef struct {
    logic [FLD_W-1:0]  tag;
    logic [FLD_W-1:0]  pri;
    logic [FLD_W-1:0]  dur;
    logic [TIME_W-1:0] wait_tm;
    logic [TIME_W-1:0] tat;
    logic [AVG_W-1:0]  avg_wait;
    logic [AVG_W-1:0]  avg_tat;
    logic              ovf;
    logic              fin;
  } sched_res_t;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 2 * MAX_JOBS + NUM_W + 16;
  localparam int RANDOM_JOBS  = 240;

  // Batch collector and schedule predictor
  class sched_scoreboard;
    job_t        batch_q[$];
    bit          dropped;
    sched_res_t  schedule_q[$];
    int unsigned errors;

    // Store or drop one transferred job; close the batch on its last job
    function void note_job(job_t job, logic last);
      job_t            order[$];
      sched_res_t      r;
      longint unsigned elapsed, total_wait, sum_turn, tat, avg;
      int              pos, n;
      if (batch_q.size() < MAX_JOBS) begin
        batch_q.push_back(job);
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      // Stable order: insert after every job of equal or smaller priority
      foreach (batch_q[i]) begin
        pos = order.size();
        for (int k = 0; k < order.size(); k++) begin
          if (order[k].pri > batch_q[i].pri) begin
            pos = k;
            break;
          end
        end
        order.insert(pos, batch_q[i]);
      end
      n = order.size();
      elapsed = 0;
      total_wait = 0;
      sum_turn = 0;
      for (int k = 0; k < n; k++) begin
        tat = elapsed + order[k].dur;
        r.tag      = order[k].tag;
        r.pri      = order[k].pri;
        r.dur      = order[k].dur;
        r.wait_tm  = (elapsed > TIME_MAX) ? TIME_MAX : elapsed[TIME_W-1:0];
        r.tat      = (tat > TIME_MAX) ? TIME_MAX : tat[TIME_W-1:0];
        r.avg_wait = '0;
        r.avg_tat  = '0;
        r.ovf      = dropped;
        r.fin      = 1'b0;
        total_wait += elapsed;
        sum_turn   += tat;
        elapsed = tat;
        if (k == n - 1) begin
          // Averages in Q8, truncated and saturated
          avg = (total_wait << 8) / n;
          r.avg_wait = (avg > AVG_MAX) ? AVG_MAX : avg[AVG_W-1:0];
          avg = (sum_turn << 8) / n;
          r.avg_tat = (avg > AVG_MAX) ? AVG_MAX : avg[AVG_W-1:0];
          r.fin = 1'b1;
        end
        schedule_q.push_back(r);
      end
      batch_q.delete();
      dropped = 1'b0;
    endfunction

    function void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compare one transferred result with the oldest expectation
    function void check_result(sched_res_t got);
      sched_res_t exp_r;
      if (schedule_q.size() == 0) begin
        $error("result with tag %0d arrived with nothing expected", got.tag);
        errors++;
        return;
      end
      exp_r = schedule_q.pop_front();
      check_field("out_tag", exp_r.tag, got.tag);
      check_field("out_priority", exp_r.pri, got.pri);
      check_field("out_duration", exp_r.dur, got.dur);
      check_field("wait_time", exp_r.wait_tm, got.wait_tm);
      check_field("turnaround_time", exp_r.tat, got.tat);
      check_field("avg_wait_q8", exp_r.avg_wait, got.avg_wait);
      check_field("avg_turnaround_q8", exp_r.avg_tat, got.avg_tat);
      check_field("overflowed", exp_r.ovf, got.ovf);
      check_field("final_res", exp_r.fin, got.fin);
    endfunction

    function int pending();
      return schedule_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FLD_W-1:0]  job_tag = '0;
  logic [FLD_W-1:0]  job_duration = '0;
  logic [FLD_W-1:0]  job_priority = '0;
  logic              batch_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [FLD_W-1:0]  out_tag;
  logic [FLD_W-1:0]  out_priority;
  logic [FLD_W-1:0]  out_duration;
  logic [TIME_W-1:0] wait_time;
  logic [TIME_W-1:0] turnaround_time;
  logic [AVG_W-1:0]  avg_wait_q8;
  logic [AVG_W-1:0]  avg_turnaround_q8;
  logic              overflowed;
  logic              final_res;

  sched_scoreboard sb = new();
  bit              burst;
  int              idle_cycles = 0;

  priority_schedule_timing u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .job_tag_i           (job_tag),
    .job_duration_i      (job_duration),
    .job_priority_i      (job_priority),
    .batch_end_i         (batch_end),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .out_tag_o           (out_tag),
    .out_priority_o      (out_priority),
    .out_duration_o      (out_duration),
    .wait_time_o         (wait_time),
    .turnaround_time_o   (turnaround_time),
    .avg_wait_q8_o       (avg_wait_q8),
    .avg_turnaround_q8_o (avg_turnaround_q8),
    .overflowed_o        (overflowed),
    .final_res_o         (final_res)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, a few long ones; none while a burst is running
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one job and hold it until transferred
  task automatic send_job(input logic [FLD_W-1:0] tag, input logic [FLD_W-1:0] dur,
                          input logic [FLD_W-1:0] pri, input logic last);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    job_tag      <= tag;
    job_duration <= dur;
    job_priority <= pri;
    batch_end    <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Record every input transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_job('{tag: job_tag, dur: job_duration, pri: job_priority}, batch_end);
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{tag: out_tag, pri: out_priority, dur: out_duration,
                        wait_tm: wait_time, tat: turnaround_time,
                        avg_wait: avg_wait_q8, avg_tat: avg_turnaround_q8,
                        ovf: overflowed, fin: final_res});
    end
  end

  // Stall the result side at random, with occasional long free-running stretches
  initial begin
    int r;
    @(posedge rst_n);
    forever begin
      out_ready <= 1'b1;
      r = $urandom_range(0, 99);
      repeat ((r < 10) ? $urandom_range(40, 150) : $urandom_range(1, 8)) @(posedge clk);
      out_ready <= 1'b0;
      r = $urandom_range(0, 99);
      repeat ((r < 88) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int sent, size, r;
    bit tie_mode;
    logic [FLD_W-1:0] pri;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Single job batch at the top of every field
    send_job(8'hFF, 8'hFF, 8'hFF, 1'b1);
    // Zero durations and zero priority ties that must keep arrival order
    send_job(8'h00, 8'h00, 8'h00, 1'b0);
    send_job(8'hA5, 8'h01, 8'h07, 1'b0);
    send_job(8'h5A, 8'h00, 8'h00, 1'b1);
    // Full store of longest jobs, then two dropped jobs, the last one closing
    for (int i = 0; i < MAX_JOBS + 2; i++) begin
      send_job(FLD_W'(i), 8'hFF, FLD_W'(255 - (i % 3) * 127), i == MAX_JOBS + 1);
    end

    // Random batches: mostly in capacity, some full or overflowing, many with ties
    sent = 0;
    while (sent < RANDOM_JOBS) begin
      r = $urandom_range(0, 99);
      if (r < 10) size = MAX_JOBS;
      else if (r < 25) size = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
      else if (r < 40) size = $urandom_range(1, 3);
      else size = $urandom_range(1, MAX_JOBS);
      tie_mode = $urandom_range(0, 1);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < size; i++) begin
        pri = tie_mode ? FLD_W'($urandom_range(0, 3)) : FLD_W'($urandom_range(0, 255));
        send_job(FLD_W'($urandom_range(0, 255)), FLD_W'($urandom_range(0, 255)), pri,
                 i == size - 1);
      end
      sent += size;
    end
    in_valid <= 1'b0;

    // Drain expectations, then watch for stray results
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
